// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;

	localparam int unsigned SLOTS_DEF     = 16;
	localparam int unsigned TIME_BITS_DEF = 16;
	localparam int unsigned MODE_W        = 2;
	localparam int unsigned SLOT_W        = 4;
	localparam int unsigned FTIME_W       = 16;
	localparam int unsigned PRIO_W        = 10;
	localparam int unsigned CNT_W         = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD  = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [SLOT_W-1:0]  slot;
		logic [FTIME_W-1:0] arrival;
		logic [FTIME_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  served_slot;
		logic               idle;
		logic               first_run;
		logic [FTIME_W-1:0] response_time;
		logic               finished;
		logic [FTIME_W-1:0] completion_time;
		logic [FTIME_W-1:0] turnaround_time;
		logic [FTIME_W-1:0] waiting_time;
		logic               all_done;
	} out_item_t;

	// Default-width token and control bundles; the top level passes its own widths.
	typedef struct packed {
		logic                     found;
		logic [SLOT_W-1:0]        idx;
		logic [PRIO_W-1:0]        prio;
		logic [TIME_BITS_DEF-1:0] arrival;
		logic [TIME_BITS_DEF-1:0] burst;
		logic [TIME_BITS_DEF-1:0] left;
		logic                     started;
		logic [CNT_W-1:0]         cnt;
	} pps_tok_t;

	typedef struct packed {
		logic                     shift;
		logic                     clear;
		logic [TIME_BITS_DEF-1:0] arrival;
		logic [TIME_BITS_DEF-1:0] burst;
		logic [PRIO_W-1:0]        prio;
		logic [TIME_BITS_DEF-1:0] now;
	} pps_ctl_t;

endpackage

// ===== rtl/core/pps_if.sv =====
interface pps_req_if;
	import pps_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pps_rsp_if;
	import pps_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler. Each request beat is one item: a load writes a task
// (arrival, burst, priority) into a slot, a tick serves one unit of time, a clear empties
// the table and zeroes the clock; mode three is ignored. Every request produces exactly one
// response beat. The task table lives in a row of SLOTS identical cells, one slot per cell.
// For every item a selection token walks the row one cell per clock: each cell checks
// whether its task has arrived and has work left, and if it beats the token's current best
// (smaller priority, then earlier arrival, then lower slot) it puts itself in the token.
// The token also counts cells with work left, which yields all_done. When the token leaves
// the last cell the result goes into the response register; on a tick the winner is also
// charged one unit and the clock advances. Each item is accepted in the idle state, walks
// the cell row in the scan state and retires in the done state; no new request is taken
// before it retires, and retiring waits while an earlier response beat is still unclaimed.
// Loads and clears also walk the row, so all_done is always current. Times wrap modulo
// 2^TIME_BITS. Load and clear responses report idle with zero fields except all_done.
module preemptive_priority_scheduler #(
	parameter int unsigned SLOTS     = pps_pkg::SLOTS_DEF,
	parameter int unsigned TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
	input logic   clk,
	input logic   arst_n,
	pps_req_if.sink   req,
	pps_rsp_if.source rsp
);
	import pps_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOTS);

	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     idx;
		logic [PRIO_W-1:0]    prio;
		logic [TIME_BITS-1:0] arrival;
		logic [TIME_BITS-1:0] burst;
		logic [TIME_BITS-1:0] left;
		logic                 started;
		logic [CNT_W-1:0]     cnt;
	} tok_t;

	typedef struct packed {
		logic                 shift;
		logic                 clear;
		logic [TIME_BITS-1:0] arrival;
		logic [TIME_BITS-1:0] burst;
		logic [PRIO_W-1:0]    prio;
		logic [TIME_BITS-1:0] now;
	} ctl_t;

	state_t state_q, state_d;
	logic [IDX_W-1:0]     scan_cnt_q;
	logic [MODE_W-1:0]    mode_q;
	logic [TIME_BITS-1:0] clock_q;
	logic                 rsp_vld_q;
	out_item_t            rsp_q;

	logic req_ready;
	logic shift_en;
	logic retire;
	logic accept;
	logic do_load;
	logic do_serve;

	ctl_t ctl;
	tok_t tok [SLOTS+1];
	tok_t win;
	logic [SLOTS-1:0] sel_load;
	logic [SLOTS-1:0] sel_serve;

	// result arithmetic
	logic                 is_tick;
	logic                 fin;
	logic [TIME_BITS-1:0] resp_t;
	logic [TIME_BITS-1:0] ct_t;
	logic [TIME_BITS-1:0] tat_t;
	logic [TIME_BITS-1:0] wt_t;
	out_item_t            res;

	assign accept  = req.valid && req_ready;
	assign do_load = accept && (req.data.mode == MODE_LOAD);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req.valid) begin
				state_d = ST_SCAN;
			end
			ST_SCAN: if (scan_cnt_q == IDX_W'(SLOTS - 1)) begin
				state_d = ST_DONE;
			end
			ST_DONE: if (!rsp_vld_q || rsp.ready) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		shift_en  = 1'b0;
		retire    = 1'b0;
		unique case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_SCAN: shift_en  = 1'b1;
			ST_DONE: retire    = !rsp_vld_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
			clock_q    <= '0;
			rsp_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (shift_en) begin
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end else begin
				scan_cnt_q <= '0;
			end
			if (accept && (req.data.mode == MODE_CLEAR)) begin
				clock_q <= '0;
			end else if (retire && is_tick) begin
				clock_q <= clock_q + TIME_BITS'(1);
			end
			if (retire) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.data.mode;
		end
		if (retire) begin
			rsp_q <= res;
		end
	end

	assign req.ready = req_ready;
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	// ---------------- cell row ----------------
	assign ctl.shift   = shift_en;
	assign ctl.clear   = accept && (req.data.mode == MODE_CLEAR);
	assign ctl.arrival = TIME_BITS'(req.data.arrival);
	assign ctl.burst   = TIME_BITS'(req.data.burst);
	assign ctl.prio    = req.data.prio;
	assign ctl.now     = clock_q;

	// token entering the first cell: nothing found, nothing counted
	assign tok[0] = '0;
	assign win    = tok[SLOTS];

	assign do_serve = retire && is_tick && win.found;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		assign sel_load[g]  = do_load && (32'(req.data.slot) == 32'(g));
		assign sel_serve[g] = do_serve && (win.idx == IDX_W'(g));

		pps_cell #(
			.IDX_W     (IDX_W),
			.TIME_BITS (TIME_BITS),
			.tok_t     (tok_t),
			.ctl_t     (ctl_t)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sel_load  (sel_load[g]),
			.sel_serve (sel_serve[g]),
			.index     (IDX_W'(g)),
			.tok_i     (tok[g]),
			.tok_o     (tok[g+1])
		);
	end

	// ---------------- result ----------------
	assign is_tick = (mode_q == MODE_TICK);
	assign fin     = (win.left == TIME_BITS'(1));
	assign resp_t  = clock_q - win.arrival;
	assign ct_t    = clock_q + TIME_BITS'(1);
	assign tat_t   = ct_t - win.arrival;
	assign wt_t    = tat_t - win.burst;

	always_comb begin
		res = '0;
		res.idle = 1'b1;
		if (is_tick && win.found) begin
			res.served_slot = SLOT_W'(win.idx);
			res.idle        = 1'b0;
			if (!win.started) begin
				res.first_run     = 1'b1;
				res.response_time = FTIME_W'(resp_t);
			end
			if (fin) begin
				res.finished        = 1'b1;
				res.completion_time = FTIME_W'(ct_t);
				res.turnaround_time = FTIME_W'(tat_t);
				res.waiting_time    = FTIME_W'(wt_t);
			end
		end
		// the winner drops out of the busy count when it finishes
		res.all_done = (win.cnt == CNT_W'(0)) ||
			(is_tick && win.found && fin && (win.cnt == CNT_W'(1)));
	end

	// ---------------- assertions ----------------
	a_rsp_from_retire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_DONE))
		else $error("response raised outside retire");

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_SCAN) && (scan_cnt_q == '0))
		else $error("accepted beat did not start a walk");

	a_busy_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.idle && !rsp.data.finished) |-> !rsp.data.all_done)
		else $error("all_done with served task still running");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.idle) |-> !rsp.data.first_run && !rsp.data.finished)
		else $error("idle response carries task events");

endmodule

// ===== rtl/core/pps_cell.sv =====
module pps_cell #(
	parameter int unsigned IDX_W     = 4,
	parameter int unsigned TIME_BITS = pps_pkg::TIME_BITS_DEF,
	parameter type tok_t = pps_pkg::pps_tok_t,
	parameter type ctl_t = pps_pkg::pps_ctl_t
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic             sel_load,
	input  logic             sel_serve,
	input  logic [IDX_W-1:0] index,
	input  tok_t             tok_i,
	output tok_t             tok_o
);
	import pps_pkg::*;

	logic                 used_q;
	logic                 started_q;
	logic [TIME_BITS-1:0] arrival_q;
	logic [TIME_BITS-1:0] burst_q;
	logic [PRIO_W-1:0]    prio_q;
	logic [TIME_BITS-1:0] left_q;
	tok_t                 tok_q;

	logic active;
	logic elig;
	logic better;
	tok_t tok_d;

	assign active = used_q && (left_q != '0);
	assign elig   = active && (arrival_q <= ctl.now);
	assign better = elig && (!tok_i.found || (prio_q < tok_i.prio) ||
		((prio_q == tok_i.prio) && (arrival_q < tok_i.arrival)));

	always_comb begin
		tok_d = tok_i;
		// saturating count of cells with work left: 0, 1, many
		if (active && (tok_i.cnt != CNT_W'(2))) begin
			tok_d.cnt = tok_i.cnt + CNT_W'(1);
		end
		if (better) begin
			tok_d.found   = 1'b1;
			tok_d.idx     = index;
			tok_d.prio    = prio_q;
			tok_d.arrival = arrival_q;
			tok_d.burst   = burst_q;
			tok_d.left    = left_q;
			tok_d.started = started_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			started_q <= 1'b0;
		end else if (ctl.clear) begin
			used_q    <= 1'b0;
			started_q <= 1'b0;
		end else if (sel_load) begin
			used_q    <= (ctl.burst != '0);
			started_q <= 1'b0;
		end else if (sel_serve) begin
			started_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel_load) begin
			arrival_q <= ctl.arrival;
			burst_q   <= ctl.burst;
			prio_q    <= ctl.prio;
			left_q    <= ctl.burst;
		end else if (sel_serve) begin
			left_q <= left_q - TIME_BITS'(1);
		end
		if (ctl.shift) begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

// ===== tb/preemptive_priority_scheduler_test.sv =====
`timescale 1ns / 100ps

module preemptive_priority_scheduler_test;
	import pps_pkg::*;

	localparam int unsigned NSLOT = SLOTS_DEF;
	// mode three carries no meaning; the block must ignore it
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
	// enough for one full walk of the cell row plus accept and retire
	localparam int unsigned SETTLE_CYCLES = NSLOT + 8;

	typedef struct {
		in_item_t item;
		bit       drain;	// hold this beat until every report is back
	} pending_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pps_req_if req_bus ();
	pps_rsp_if rsp_bus ();

	preemptive_priority_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always #5 clk = ~clk;

	// Task table as the scheduler should see it.
	bit                 tk_used    [NSLOT];
	bit                 tk_started [NSLOT];
	logic [FTIME_W-1:0] tk_arrival [NSLOT];
	logic [FTIME_W-1:0] tk_burst   [NSLOT];
	logic [FTIME_W-1:0] tk_left    [NSLOT];
	logic [PRIO_W-1:0]  tk_prio    [NSLOT];
	logic [FTIME_W-1:0] tk_now = '0;

	pending_item_t pending_items[$];
	out_item_t     pending_reports[$];

	int unsigned items_made = 0;
	int unsigned mismatches = 0;
	int unsigned req_gap = 0;
	int unsigned rsp_gap = 0;
	int unsigned phase_left = 0;
	bit          calm = 1'b0;
	bit          req_fire = 1'b0;
	bit          rsp_fire = 1'b0;

	// Apply one beat to the task table and return the report it must produce.
	function automatic out_item_t schedule_item(in_item_t it);
		out_item_t          r;
		bit                 found;
		int unsigned        best;
		logic [FTIME_W-1:0] ct;
		logic [FTIME_W-1:0] tat;
		r = '0;
		r.idle = 1'b1;
		found = 1'b0;
		best = 0;
		case (it.mode)
		MODE_LOAD: begin
			// burst of zero empties the slot; a reload counts as not started
			tk_used[it.slot]    = (it.burst != '0);
			tk_arrival[it.slot] = it.arrival;
			tk_burst[it.slot]   = it.burst;
			tk_left[it.slot]    = it.burst;
			tk_prio[it.slot]    = it.prio;
			tk_started[it.slot] = 1'b0;
		end
		MODE_CLEAR: begin
			for (int i = 0; i < NSLOT; i++) begin
				tk_used[i]    = 1'b0;
				tk_started[i] = 1'b0;
			end
			tk_now = '0;
		end
		MODE_TICK: begin
			// strict compares keep the lowest slot on a full tie
			for (int i = 0; i < NSLOT; i++) begin
				if (tk_used[i] && tk_left[i] != '0 && tk_arrival[i] <= tk_now) begin
					if (!found || tk_prio[i] < tk_prio[best] ||
					    (tk_prio[i] == tk_prio[best] && tk_arrival[i] < tk_arrival[best])) begin
						found = 1'b1;
						best = i;
					end
				end
			end
			if (found) begin
				r.served_slot = best[SLOT_W-1:0];
				r.idle = 1'b0;
				if (!tk_started[best]) begin
					tk_started[best] = 1'b1;
					r.first_run = 1'b1;
					r.response_time = tk_now - tk_arrival[best];
				end
				tk_left[best] = tk_left[best] - 1'b1;
				if (tk_left[best] == '0) begin
					ct = tk_now + 1'b1;
					tat = ct - tk_arrival[best];
					r.finished = 1'b1;
					r.completion_time = ct;
					r.turnaround_time = tat;
					r.waiting_time = tat - tk_burst[best];
				end
			end
			// clock moves on every tick, served or idle
			tk_now = tk_now + 1'b1;
		end
		default: ;
		endcase
		r.all_done = 1'b1;
		for (int i = 0; i < NSLOT; i++) begin
			if (tk_used[i] && tk_left[i] != '0)
				r.all_done = 1'b0;
		end
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Mostly no pause, sometimes a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_item(logic [MODE_W-1:0] mode, int unsigned slot,
			int unsigned arrival, int unsigned burst, int unsigned prio, bit drain);
		pending_item_t p;
		p.item.mode    = mode;
		p.item.slot    = slot[SLOT_W-1:0];
		p.item.arrival = arrival[FTIME_W-1:0];
		p.item.burst   = burst[FTIME_W-1:0];
		p.item.prio    = prio[PRIO_W-1:0];
		p.drain        = drain;
		pending_items.push_back(p);
		items_made++;
	endtask

	function automatic int unsigned pick_burst();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 0;
		if (r < 7)
			return $urandom_range(7, 30);
		return $urandom_range(1, 6);
	endfunction

	// Many ties at low values, the rest spread over the whole field.
	function automatic int unsigned pick_prio();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(0, 3);
		if (r < 90)
			return $urandom_range(0, 998);
		return $urandom_range(999, 1023);
	endfunction

	// One workload: usually a clear, a handful of loads, then enough ticks to run
	// the table dry, with late arrivals (preemption), drops and mode-three noise mixed in.
	task automatic make_batch(bit drain_first);
		bit          fresh;
		int unsigned n;
		int unsigned ticks;
		int unsigned t;
		int unsigned a;
		int unsigned b;
		int unsigned r;
		int unsigned max_arr;
		fresh = drain_first || ($urandom_range(0, 4) != 0);
		if (fresh)
			queue_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
				drain_first || ($urandom_range(0, 7) == 0));
		n = $urandom_range(1, 6);
		ticks = $urandom_range(0, 3);
		max_arr = 0;
		for (int k = 0; k < n; k++) begin
			a = $urandom_range(0, 12);
			b = pick_burst();
			if (a > max_arr)
				max_arr = a;
			ticks += b;
			queue_item(MODE_LOAD, $urandom_range(0, NSLOT - 1), a, b, pick_prio(), 1'b0);
		end
		ticks += max_arr;
		t = 0;
		while (t < ticks) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				queue_item(MODE_NONE, $urandom, $urandom, $urandom, $urandom, 1'b0);
			end else if (r < 14) begin
				a = t + $urandom_range(0, 3);
				b = pick_burst();
				if (ticks < 80)
					ticks += b + 3;
				queue_item(MODE_LOAD, $urandom_range(0, NSLOT - 1), a, b, pick_prio(), 1'b0);
			end else if (r < 17) begin
				queue_item(MODE_LOAD, $urandom_range(0, NSLOT - 1), $urandom, 0, $urandom,
					1'b0);
			end else begin
				queue_item(MODE_TICK, $urandom, $urandom, $urandom, $urandom, 1'b0);
				t++;
			end
		end
	endtask

	// Request side: new beat offered at the falling edge once the last one went through.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.data  <= '0;
		end else if (!req_bus.valid || req_fire) begin
			if (req_fire)
				req_gap = pick_gap();
			if (req_gap > 0) begin
				req_gap--;
				req_bus.valid <= 1'b0;
			end else if (pending_items.size() != 0 &&
			             !(pending_items[0].drain && pending_reports.size() != 0)) begin
				req_bus.data  <= pending_items[0].item;
				req_bus.valid <= 1'b1;
				pending_items.delete(0);
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// Response side: random back-pressure, with calm stretches of none at all.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (phase_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				phase_left = $urandom_range(50, 300);
			end else begin
				phase_left--;
			end
			if (rsp_fire)
				rsp_gap = pick_gap();
			if (rsp_gap > 0) begin
				rsp_gap--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// Both channels sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		req_fire = arst_n && req_bus.valid && req_bus.ready;
		rsp_fire = arst_n && rsp_bus.valid && rsp_bus.ready;
		if (req_fire)
			pending_reports.push_back(schedule_item(req_bus.data));
		if (rsp_fire) begin
			got = rsp_bus.data;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report beat with none expected: %p", got);
			end else begin
				want = pending_reports.pop_front();
				check_field("served_slot", 32'(want.served_slot), 32'(got.served_slot));
				check_field("idle", 32'(want.idle), 32'(got.idle));
				check_field("first_run", 32'(want.first_run), 32'(got.first_run));
				check_field("response_time", 32'(want.response_time),
					32'(got.response_time));
				check_field("finished", 32'(want.finished), 32'(got.finished));
				check_field("completion_time", 32'(want.completion_time),
					32'(got.completion_time));
				check_field("turnaround_time", 32'(want.turnaround_time),
					32'(got.turnaround_time));
				check_field("waiting_time", 32'(want.waiting_time), 32'(got.waiting_time));
				check_field("all_done", 32'(want.all_done), 32'(got.all_done));
			end
		end
	end

	initial begin
		// directed: idle tick on an empty table, then a one-beat task
		queue_item(MODE_TICK, 0, 0, 0, 0, 1'b0);
		queue_item(MODE_CLEAR, 0, 0, 0, 0, 1'b0);
		queue_item(MODE_LOAD, 0, 0, 1, 0, 1'b0);
		queue_item(MODE_TICK, 0, 0, 0, 0, 1'b0);
		// top priority value ties: lower slot wins, later arrival loses
		queue_item(MODE_LOAD, 15, 0, 2, 1023, 1'b0);
		queue_item(MODE_LOAD, 3, 0, 2, 1023, 1'b0);
		queue_item(MODE_LOAD, 9, 1, 1, 1023, 1'b0);
		queue_item(MODE_LOAD, 12, 0, 3, 998, 1'b0);
		queue_item(MODE_TICK, 0, 0, 0, 0, 1'b0);
		// drop a started task, replace an unstarted one
		queue_item(MODE_LOAD, 12, 65535, 0, 1023, 1'b0);
		queue_item(MODE_LOAD, 3, 0, 1, 1023, 1'b0);
		queue_item(MODE_NONE, 15, 65535, 65535, 1023, 1'b0);
		for (int k = 0; k < 5; k++)
			queue_item(MODE_TICK, 15, 65535, 65535, 1023, 1'b0);
		// a task that never arrives, and one that never finishes
		queue_item(MODE_LOAD, 7, 65535, 65535, 1023, 1'b0);
		queue_item(MODE_TICK, 0, 0, 0, 0, 1'b0);
		queue_item(MODE_LOAD, 6, 0, 65535, 0, 1'b0);
		queue_item(MODE_TICK, 0, 0, 0, 0, 1'b0);
		queue_item(MODE_CLEAR, 15, 65535, 65535, 1023, 1'b0);
		queue_item(MODE_TICK, 0, 0, 0, 0, 1'b0);

		// random workloads; the first waits for the directed part to drain
		make_batch(1'b1);
		while (items_made < 680)
			make_batch(1'b0);

		repeat (11) @(posedge clk);
		#2 arst_n = 1'b1;

		wait (pending_items.size() == 0 && !req_bus.valid);
		wait (pending_reports.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog with ample room for about 700 beats
	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== preemptive_priority_scheduler.f =====
rtl/core/pps_pkg.sv
rtl/core/pps_if.sv
rtl/core/pps_cell.sv
rtl/core/preemptive_priority_scheduler.sv
tb/preemptive_priority_scheduler_test.sv
